@@ rtl/core/worker_restart_supervisor_backoff_unit_defines.svh @@
// Assertion macros shared by the supervisor RTL.
`ifndef WORKER_RESTART_SUPERVISOR_BACKOFF_UNIT_DEFINES_SVH
`define WORKER_RESTART_SUPERVISOR_BACKOFF_UNIT_DEFINES_SVH

`ifndef SYNTH
// Checked property, masked while reset is high.
`define WRSB_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("wrsb assertion failed");
// Checked property, also evaluated during reset.
`define WRSB_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("wrsb assertion failed");
`else
`define WRSB_ASSERT(name, clk, rst, prop)
`define WRSB_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

@@ rtl/core/wrsb_pkg.sv @@
// Types, codes, reset values and helper functions for the restart supervisor.
`default_nettype none

package wrsb_pkg;

  localparam int TIME_W    = 32;
  localparam int CFG_W     = 24;
  localparam int THR_W     = 8;
  localparam int STREAK_W  = 16;
  localparam int CNT_OUT_W = 32;
  localparam int DL_W      = TIME_W + 1;
  localparam int SHIFT_CAP = CFG_W;
  localparam int SHIFT_W   = $clog2(SHIFT_CAP + 1);
  localparam int REG_IDX_W = 3;

  typedef logic [2:0] phase_t;
  localparam phase_t PH_STOPPED  = 3'd0;
  localparam phase_t PH_STARTING = 3'd1;
  localparam phase_t PH_READY    = 3'd2;
  localparam phase_t PH_DEGRADED = 3'd3;
  localparam phase_t PH_BLOCKED  = 3'd4;

  typedef logic [1:0] action_t;
  localparam action_t ACT_START   = 2'd0;
  localparam action_t ACT_STOP    = 2'd1;
  localparam action_t ACT_POLL    = 2'd2;
  localparam action_t ACT_RESTART = 2'd3;

  typedef logic [1:0] fkind_t;
  localparam fkind_t FK_NONE  = 2'd0;
  localparam fkind_t FK_START = 2'd1;
  localparam fkind_t FK_EXIT  = 2'd2;
  localparam fkind_t FK_STALL = 2'd3;

  typedef logic [2:0] cmd_t;
  localparam cmd_t CMD_NONE  = 3'b000;
  localparam cmd_t CMD_START = 3'b001;
  localparam cmd_t CMD_STOP  = 3'b010;
  localparam cmd_t CMD_FLUSH = 3'b100;

  typedef logic [REG_IDX_W-1:0] reg_idx_t;
  localparam reg_idx_t REG_START_LIMIT     = 3'd0;
  localparam reg_idx_t REG_STALL_LIMIT     = 3'd1;
  localparam reg_idx_t REG_STABLE_RESET    = 3'd2;
  localparam reg_idx_t REG_BO_FIRST        = 3'd3;
  localparam reg_idx_t REG_BO_CAP          = 3'd4;
  localparam reg_idx_t REG_BLOCK_THRESHOLD = 3'd5;

  localparam logic [CFG_W-1:0] RST_START_LIMIT     = 24'd2000;
  localparam logic [CFG_W-1:0] RST_STALL_LIMIT     = 24'd1000;
  localparam logic [CFG_W-1:0] RST_STABLE_RESET    = 24'd30000;
  localparam logic [CFG_W-1:0] RST_BO_FIRST        = 24'd500;
  localparam logic [CFG_W-1:0] RST_BO_CAP          = 24'd30000;
  localparam logic [THR_W-1:0] RST_BLOCK_THRESHOLD = 8'd5;

  typedef struct packed {
    phase_t                phase;
    fkind_t                failure_kind;
    logic [STREAK_W-1:0]   failure_run;
    logic [CNT_OUT_W-1:0]  attempt_count;
    logic [CNT_OUT_W-1:0]  boundary_count;
    logic [CNT_OUT_W-1:0]  exit_count;
    logic [CNT_OUT_W-1:0]  stall_count;
    logic [CNT_OUT_W-1:0]  planned_count;
    logic                  retry_pending;
    logic [TIME_W-1:0]     retry_wait_ms;
    cmd_t                  commands;
  } result_t;

  // now - since >= span, with a clock that ran backwards counting as not elapsed
  function automatic logic elapsed_at_least(input logic [TIME_W-1:0] now,
                                            input logic [TIME_W-1:0] since,
                                            input logic [CFG_W-1:0]  span);
    logic [TIME_W-1:0] diff;
    diff = now - since;
    return (now >= since) && (diff >= TIME_W'(span));
  endfunction

  // min(initial << (streak-1), maximum); a maximum below initial keeps initial.
  // Shift is capped at the config width: beyond that any nonzero initial is past the cap.
  function automatic logic [CFG_W-1:0] backoff_delay(input logic [CFG_W-1:0]    init,
                                                     input logic [CFG_W-1:0]    maxv,
                                                     input logic [STREAK_W-1:0] streak);
    logic [STREAK_W-1:0] k;
    logic [SHIFT_W-1:0]  sh;
    logic [2*CFG_W-1:0]  wide;
    logic [CFG_W-1:0]    r;
    k = streak - STREAK_W'(1);
    sh = (k >= STREAK_W'(SHIFT_CAP)) ? SHIFT_W'(SHIFT_CAP) : k[SHIFT_W-1:0];
    wide = {{CFG_W{1'b0}}, init} << sh;
    if (init >= maxv) begin
      r = init;
    end else if (wide > {{CFG_W{1'b0}}, maxv}) begin
      r = maxv;
    end else begin
      r = wide[CFG_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/wrsb_if.sv @@
// Channel interfaces: event input, result output and register write port.
`default_nettype none

interface wrsb_evt_if;
  import wrsb_pkg::*;
  logic              valid;
  logic              ready;
  action_t           action;
  logic [TIME_W-1:0] now_ms;
  logic              start_ok;
  logic              worker_running;
  logic [TIME_W-1:0] last_period_ms;
  modport source (output valid, action, now_ms, start_ok, worker_running, last_period_ms,
                  input ready);
  modport sink   (input valid, action, now_ms, start_ok, worker_running, last_period_ms,
                  output ready);
endinterface

interface wrsb_res_if;
  import wrsb_pkg::*;
  logic                 valid;
  logic                 ready;
  phase_t               phase;
  fkind_t               failure_kind;
  logic [STREAK_W-1:0]  failure_run;
  logic [CNT_OUT_W-1:0] attempt_count;
  logic [CNT_OUT_W-1:0] boundary_count;
  logic [CNT_OUT_W-1:0] exit_count;
  logic [CNT_OUT_W-1:0] stall_count;
  logic [CNT_OUT_W-1:0] planned_count;
  logic                 retry_pending;
  logic [TIME_W-1:0]    retry_wait_ms;
  cmd_t                 commands;
  modport source (output valid, phase, failure_kind, failure_run, attempt_count,
                  boundary_count, exit_count, stall_count, planned_count,
                  retry_pending, retry_wait_ms, commands,
                  input ready);
  modport sink   (input valid, phase, failure_kind, failure_run, attempt_count,
                  boundary_count, exit_count, stall_count, planned_count,
                  retry_pending, retry_wait_ms, commands,
                  output ready);
endinterface

interface wrsb_cfg_if;
  import wrsb_pkg::*;
  logic             valid;
  logic             ready;
  reg_idx_t         idx;
  logic [CFG_W-1:0] data;
  modport source (output valid, idx, data, input ready);
  modport sink   (input valid, idx, data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/worker_restart_supervisor_backoff_unit.sv @@
// Worker restart supervisor with doubling retry backoff.
//
//   channel  dir  fields                                              transfer
//   evt      in   action, now_ms, start_ok, worker_running,           valid & ready
//                 last_period_ms
//   res      out  phase, failure_kind, failure_run, *_count,          valid & ready
//                 retry_pending, retry_wait_ms, commands
//   cfg      in   idx, data (register write)                          valid & ready
//
// One event per cycle while evt.ready is high; the result is registered onto res.
// The state update and result are one combinational pass from the state registers.
// Result register plus a one-entry skid: evt.ready drops only when both hold data.
// cfg.ready is always high. Synchronous reset loads register defaults, phase stopped,
// counters zero; no clearing pass.
`default_nettype none
`include "worker_restart_supervisor_backoff_unit_defines.svh"

module worker_restart_supervisor_backoff_unit #(
  parameter int COUNTER_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  wrsb_evt_if.sink   evt,
  wrsb_res_if.source res,
  wrsb_cfg_if.sink   cfg
);
  import wrsb_pkg::*;

  // configuration
  logic [CFG_W-1:0] start_limit;
  logic [CFG_W-1:0] stall_limit;
  logic [CFG_W-1:0] stable_reset;
  logic [CFG_W-1:0] bo_first;
  logic [CFG_W-1:0] bo_cap;
  logic [THR_W-1:0] block_threshold;

  // supervisor state
  phase_t                  lifecycle, lifecycle_next;
  fkind_t                  fail_reason, fail_reason_next;
  logic [STREAK_W-1:0]     fail_streak, fail_streak_next;
  logic [COUNTER_BITS-1:0] attempts, attempts_next;
  logic [COUNTER_BITS-1:0] boundaries, boundaries_next;
  logic [COUNTER_BITS-1:0] exits, exits_next;
  logic [COUNTER_BITS-1:0] stalls, stalls_next;
  logic [COUNTER_BITS-1:0] planned, planned_next;
  logic                    retry_flag, retry_flag_next;
  logic [DL_W-1:0]         retry_deadline, retry_deadline_next;
  logic [TIME_W-1:0]       attempt_time, attempt_time_next;
  logic [TIME_W-1:0]       ready_time, ready_time_next;

  // output staging
  result_t res_data, skid_data, result;
  logic    res_v, skid_v;

  logic              acc, take;
  logic              active, do_start, fail, fresh;
  fkind_t            kind;
  cmd_t              cmds;
  logic [CFG_W-1:0]  delay;
  logic [DL_W-1:0]   wait_diff;
  logic [TIME_W-1:0] wait_ms;
  logic [TIME_W-1:0] period_age;

  assign evt.ready = !skid_v;
  assign acc       = evt.valid && evt.ready;
  assign take      = res_v && res.ready;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_limit     <= RST_START_LIMIT;
      stall_limit     <= RST_STALL_LIMIT;
      stable_reset    <= RST_STABLE_RESET;
      bo_first        <= RST_BO_FIRST;
      bo_cap          <= RST_BO_CAP;
      block_threshold <= RST_BLOCK_THRESHOLD;
    end else if (cfg.valid) begin
      unique case (cfg.idx)
        REG_START_LIMIT:     start_limit     <= cfg.data;
        REG_STALL_LIMIT:     stall_limit     <= cfg.data;
        REG_STABLE_RESET:    stable_reset    <= cfg.data;
        REG_BO_FIRST:        bo_first        <= cfg.data;
        REG_BO_CAP:          bo_cap          <= cfg.data;
        REG_BLOCK_THRESHOLD: block_threshold <= cfg.data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  assign active     = (lifecycle != PH_STOPPED);
  assign period_age = evt.now_ms - evt.last_period_ms;
  assign fresh      = (evt.last_period_ms != '0) && (evt.now_ms >= evt.last_period_ms) &&
                      (period_age <= TIME_W'(stall_limit));

  always_comb begin
    lifecycle_next      = lifecycle;
    fail_reason_next    = fail_reason;
    fail_streak_next    = fail_streak;
    attempts_next       = attempts;
    boundaries_next     = boundaries;
    exits_next          = exits;
    stalls_next         = stalls;
    planned_next        = planned;
    retry_flag_next     = retry_flag;
    retry_deadline_next = retry_deadline;
    attempt_time_next   = attempt_time;
    ready_time_next     = ready_time;
    cmds                = CMD_NONE;
    do_start            = 1'b0;
    fail                = 1'b0;
    kind                = FK_NONE;
    delay               = '0;

    unique case (evt.action)
      ACT_START: begin
        if (!active) begin
          cmds     = cmds | CMD_FLUSH;
          do_start = 1'b1;
        end
      end
      ACT_STOP: begin
        if (active) begin
          cmds            = cmds | CMD_STOP;
          retry_flag_next = 1'b0;
          lifecycle_next  = PH_STOPPED;
        end
      end
      ACT_POLL: begin
        if (lifecycle == PH_DEGRADED || lifecycle == PH_BLOCKED) begin
          if ({1'b0, evt.now_ms} >= retry_deadline) do_start = 1'b1;
        end else if (lifecycle == PH_STARTING) begin
          if (!evt.worker_running) begin
            fail = 1'b1;
            kind = FK_EXIT;
          end else if (fresh) begin
            ready_time_next = evt.now_ms;
            lifecycle_next  = PH_READY;
          end else if (elapsed_at_least(evt.now_ms, attempt_time, start_limit)) begin
            fail = 1'b1;
            kind = FK_STALL;
          end
        end else if (lifecycle == PH_READY) begin
          if (!evt.worker_running) begin
            fail = 1'b1;
            kind = FK_EXIT;
          end else if (!fresh) begin
            fail = 1'b1;
            kind = FK_STALL;
          end else if (fail_streak != '0 &&
                       elapsed_at_least(evt.now_ms, ready_time, stable_reset)) begin
            fail_streak_next = '0;
            fail_reason_next = FK_NONE;
          end
        end
      end
      ACT_RESTART: begin
        if (active) begin
          cmds             = cmds | CMD_STOP | CMD_FLUSH;
          boundaries_next  = boundaries_next + COUNTER_BITS'(1);
          planned_next     = planned + COUNTER_BITS'(1);
          fail_reason_next = FK_NONE;
          fail_streak_next = '0;
          do_start         = 1'b1;
        end
      end
      default: ;
    endcase

    if (do_start) begin
      cmds              = cmds | CMD_START;
      attempts_next     = attempts + COUNTER_BITS'(1);
      retry_flag_next   = 1'b0;
      attempt_time_next = evt.now_ms;
      lifecycle_next    = PH_STARTING;
      if (!evt.start_ok) begin
        fail = 1'b1;
        kind = FK_START;
      end
    end

    if (fail) begin
      cmds            = cmds | CMD_STOP | CMD_FLUSH;
      boundaries_next = boundaries_next + COUNTER_BITS'(1);
      if (fail_streak_next != '1) fail_streak_next = fail_streak_next + STREAK_W'(1);
      fail_reason_next = kind;
      if (kind == FK_EXIT)  exits_next  = exits + COUNTER_BITS'(1);
      if (kind == FK_STALL) stalls_next = stalls + COUNTER_BITS'(1);
      delay               = backoff_delay(bo_first, bo_cap, fail_streak_next);
      retry_deadline_next = {1'b0, evt.now_ms} + DL_W'(delay);
      retry_flag_next     = 1'b1;
      lifecycle_next      = (fail_streak_next >= STREAK_W'(block_threshold)) ?
                            PH_BLOCKED : PH_DEGRADED;
    end
  end

  // wait from a fresh failure is the delay itself; otherwise it comes from the held deadline
  assign wait_diff = retry_deadline - {1'b0, evt.now_ms};

  always_comb begin
    if (fail) begin
      wait_ms = TIME_W'(delay);
    end else if (retry_flag_next && (retry_deadline > {1'b0, evt.now_ms})) begin
      wait_ms = wait_diff[DL_W-1] ? '1 : wait_diff[TIME_W-1:0];
    end else begin
      wait_ms = '0;
    end
  end

  always_comb begin
    result.phase          = lifecycle_next;
    result.failure_kind   = fail_reason_next;
    result.failure_run    = fail_streak_next;
    result.attempt_count  = CNT_OUT_W'(attempts_next);
    result.boundary_count = CNT_OUT_W'(boundaries_next);
    result.exit_count     = CNT_OUT_W'(exits_next);
    result.stall_count    = CNT_OUT_W'(stalls_next);
    result.planned_count  = CNT_OUT_W'(planned_next);
    result.retry_pending  = retry_flag_next;
    result.retry_wait_ms  = wait_ms;
    result.commands       = cmds;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lifecycle      <= PH_STOPPED;
      fail_reason    <= FK_NONE;
      fail_streak    <= '0;
      attempts       <= '0;
      boundaries     <= '0;
      exits          <= '0;
      stalls         <= '0;
      planned        <= '0;
      retry_flag     <= 1'b0;
      retry_deadline <= '0;
      attempt_time   <= '0;
      ready_time     <= '0;
    end else if (acc) begin
      lifecycle      <= lifecycle_next;
      fail_reason    <= fail_reason_next;
      fail_streak    <= fail_streak_next;
      attempts       <= attempts_next;
      boundaries     <= boundaries_next;
      exits          <= exits_next;
      stalls         <= stalls_next;
      planned        <= planned_next;
      retry_flag     <= retry_flag_next;
      retry_deadline <= retry_deadline_next;
      attempt_time   <= attempt_time_next;
      ready_time     <= ready_time_next;
    end
  end

  // result register with a one-entry skid behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      res_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (!res_v || take) begin
      if (skid_v) begin
        res_v  <= 1'b1;
        skid_v <= 1'b0;
      end else begin
        res_v <= acc;
      end
    end else if (acc) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!res_v || take) begin
      if (skid_v) begin
        res_data <= skid_data;
      end else if (acc) begin
        res_data <= result;
      end
    end else if (acc) begin
      skid_data <= result;
    end
  end

  assign res.valid          = res_v;
  assign res.phase          = res_data.phase;
  assign res.failure_kind   = res_data.failure_kind;
  assign res.failure_run    = res_data.failure_run;
  assign res.attempt_count  = res_data.attempt_count;
  assign res.boundary_count = res_data.boundary_count;
  assign res.exit_count     = res_data.exit_count;
  assign res.stall_count    = res_data.stall_count;
  assign res.planned_count  = res_data.planned_count;
  assign res.retry_pending  = res_data.retry_pending;
  assign res.retry_wait_ms  = res_data.retry_wait_ms;
  assign res.commands       = res_data.commands;

  `WRSB_ASSERT_ALWAYS(a_skid_behind_result, clk, skid_v |-> res_v)
  `WRSB_ASSERT(a_retry_only_after_failure, clk, rst,
               retry_flag |-> (lifecycle == PH_DEGRADED || lifecycle == PH_BLOCKED))
  `WRSB_ASSERT(a_clear_run_clears_reason, clk, rst,
               (fail_streak == '0) |-> (fail_reason == FK_NONE))
  `WRSB_ASSERT(a_accept_into_empty, clk, rst,
               (acc && !res_v) |=> (res_v && !skid_v))

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking restart supervisor bench: directed event table, then random events per register set.
`timescale 1ns / 1ps

module tb_top;
  import wrsb_pkg::*;

  typedef struct packed {
    action_t           act;
    logic [TIME_W-1:0] now;
    logic              ok;
    logic              run;
    logic [TIME_W-1:0] last;
    logic              hand;   // phase, kind and commands below are typed in
    phase_t            ph;
    fkind_t            fk;
    cmd_t              cmd;
  } sup_event_t;

  typedef struct packed {
    logic [CFG_W-1:0] startup, stall, stable, init_bo, max_bo;
    logic [THR_W-1:0] thr;
  } reg_set_t;

  logic clk;
  logic rst;

  wrsb_evt_if evt ();
  wrsb_res_if res ();
  wrsb_cfg_if cfg ();

  worker_restart_supervisor_backoff_unit u_dut (
    .clk (clk),
    .rst (rst),
    .evt (evt),
    .res (res),
    .cfg (cfg)
  );

  // typed-in expectations travel beside the event they belong to
  logic   hand_chk;
  phase_t hand_ph;
  fkind_t hand_fk;
  cmd_t   hand_cmd;

  // bring-up walk under reset register values
  sup_event_t bringup [27] = '{
    '{ACT_POLL,    32'd0,          1'b0, 1'b0, 32'd0,          1'b1, PH_STOPPED,  FK_NONE,
      CMD_NONE},
    '{ACT_STOP,    32'd100,        1'b1, 1'b1, 32'd50,         1'b1, PH_STOPPED,  FK_NONE,
      CMD_NONE},
    '{ACT_RESTART, 32'd100,        1'b1, 1'b1, 32'd50,         1'b1, PH_STOPPED,  FK_NONE,
      CMD_NONE},
    '{ACT_START,   32'd1000,       1'b1, 1'b0, 32'd0,          1'b1, PH_STARTING, FK_NONE,
      CMD_START | CMD_FLUSH},
    '{ACT_START,   32'd1100,       1'b1, 1'b1, 32'd0,          1'b1, PH_STARTING, FK_NONE,
      CMD_NONE},
    '{ACT_POLL,    32'd1500,       1'b1, 1'b1, 32'd0,          1'b0, PH_STOPPED,  FK_NONE,
      CMD_NONE},
    '{ACT_POLL,    32'd1600,       1'b1, 1'b1, 32'd1550,       1'b0, PH_STOPPED,  FK_NONE,
      CMD_NONE},
    '{ACT_POLL,    32'd2000,       1'b1, 1'b1, 32'd1900,       1'b0, PH_STOPPED,  FK_NONE,
      CMD_NONE},
    '{ACT_POLL,    32'd3000,       1'b1, 1'b1, 32'd1500,       1'b1, PH_DEGRADED, FK_STALL,
      CMD_STOP | CMD_FLUSH},
    '{ACT_POLL,    32'd3200,       1'b1, 1'b1, 32'd3100,       1'b0, PH_STOPPED,  FK_NONE,
      CMD_NONE},
    '{ACT_POLL,    32'd3500,       1'b0, 1'b1, 32'd3400,       1'b1, PH_DEGRADED, FK_START,
      CMD_START | CMD_STOP | CMD_FLUSH},
    '{ACT_POLL,    32'd4500,       1'b1, 1'b1, 32'd0,          1'b0, PH_STOPPED,  FK_NONE,
      CMD_NONE},
    '{ACT_POLL,    32'd4600,       1'b1, 1'b0, 32'd4550,       1'b1, PH_DEGRADED, FK_EXIT,
      CMD_STOP | CMD_FLUSH},
    '{ACT_POLL,    32'd6600,       1'b1, 1'b1, 32'd0,          1'b0, PH_STOPPED,  FK_NONE,
      CMD_NONE},
    '{ACT_POLL,    32'd9000,       1'b1, 1'b1, 32'd0,          1'b0, PH_STOPPED,  FK_NONE,
      CMD_NONE},
    '{ACT_POLL,    32'd5000,       1'b1, 1'b1, 32'd4900,       1'b0, PH_STOPPED,  FK_NONE,
      CMD_NONE},
    '{ACT_POLL,    32'd13000,      1'b0, 1'b1, 32'd12900,      1'b1, PH_BLOCKED,  FK_START,
      CMD_START | CMD_STOP | CMD_FLUSH},
    '{ACT_POLL,    32'hFFFF_FFFF,  1'b1, 1'b1, 32'd0,          1'b0, PH_STOPPED,  FK_NONE,
      CMD_NONE},
    '{ACT_POLL,    32'hFFFF_FFFF,  1'b1, 1'b1, 32'hFFFF_FFFF,  1'b0, PH_STOPPED,  FK_NONE,
      CMD_NONE},
    '{ACT_POLL,    32'd100,        1'b1, 1'b1, 32'd200,        1'b1, PH_BLOCKED,  FK_STALL,
      CMD_STOP | CMD_FLUSH},
    '{ACT_RESTART, 32'd200,        1'b1, 1'b1, 32'd0,          1'b1, PH_STARTING, FK_NONE,
      CMD_START | CMD_STOP | CMD_FLUSH},
    '{ACT_POLL,    32'd300,        1'b1, 1'b1, 32'd250,        1'b0, PH_STOPPED,  FK_NONE,
      CMD_NONE},
    '{ACT_STOP,    32'd400,        1'b1, 1'b1, 32'd350,        1'b1, PH_STOPPED,  FK_NONE,
      CMD_STOP},
    '{ACT_START,   32'd500,        1'b0, 1'b0, 32'd0,          1'b1, PH_DEGRADED, FK_START,
      CMD_START | CMD_STOP | CMD_FLUSH},
    '{ACT_POLL,    32'd1000,       1'b1, 1'b1, 32'd0,          1'b0, PH_STOPPED,  FK_NONE,
      CMD_NONE},
    '{ACT_POLL,    32'd1100,       1'b1, 1'b1, 32'd1050,       1'b0, PH_STOPPED,  FK_NONE,
      CMD_NONE},
    '{ACT_POLL,    32'd31100,      1'b1, 1'b1, 32'd31000,      1'b1, PH_READY,    FK_NONE,
      CMD_NONE}
  };

  reg_set_t reg_sets [6] = '{
    '{24'd1, 24'd1, 24'd1, 24'd1, 24'd1, 8'd1},
    '{24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 8'd255},
    '{24'd50, 24'd20, 24'd300, 24'd0, 24'd100, 8'd0},        // retry due at once, always blocked
    '{24'd200, 24'd100, 24'd1000, 24'd10, 24'd300, 8'd4},
    '{24'd400, 24'd150, 24'd2000, 24'd500, 24'd100, 8'd8},   // cap below initial delay
    '{RST_START_LIMIT, RST_STALL_LIMIT, RST_STABLE_RESET, RST_BO_FIRST,
      RST_BO_CAP, RST_BLOCK_THRESHOLD}
  };

  // supervisor mirror
  logic [CFG_W-1:0]     to_startup, to_stall, to_stable, bo_init, bo_max;
  logic [THR_W-1:0]     block_at;
  phase_t               sup_phase;
  fkind_t               sup_kind;
  logic [STREAK_W-1:0]  sup_streak;
  logic [CNT_OUT_W-1:0] n_attempts, n_boundaries, n_exits, n_stalls, n_planned;
  logic                 retry_armed;
  logic [DL_W-1:0]      retry_due;
  logic [TIME_W-1:0]    attempt_at, ready_at;
  cmd_t                 cmd_acc;

  result_t     status_q [$];
  result_t     want_r;
  result_t     pred_r;
  sup_event_t  seen_ev;
  int          outstanding;
  int unsigned accepted_n;
  int unsigned mismatch_n = 0;
  phase_t      steer_phase;
  logic [31:0] time_cursor = 32'd0;
  int unsigned burst_left = 0;

  function automatic logic fresh_period(logic [31:0] now, logic [31:0] last);
    return last != 32'd0 && now >= last && (now - last) <= 32'(to_stall);
  endfunction

  function automatic logic has_elapsed(logic [31:0] now, logic [31:0] since,
                                       logic [CFG_W-1:0] span);
    return now >= since && (now - since) >= 32'(span);
  endfunction

  task automatic log_failure(fkind_t kind, logic [31:0] now);
    longint unsigned delay;
    int unsigned n;
    cmd_acc = cmd_acc | CMD_STOP | CMD_FLUSH;
    n_boundaries++;
    if (sup_streak != 16'hFFFF) sup_streak++;
    sup_kind = kind;
    if (kind == FK_EXIT) n_exits++;
    if (kind == FK_STALL) n_stalls++;
    // doubling stops at the cap; a zero delay never grows
    delay = bo_init;
    for (n = 1; n < sup_streak && delay < bo_max && delay != 0; n++) begin
      delay = delay * 2;
      if (delay > bo_max) delay = bo_max;
    end
    retry_due = {1'b0, now} + 33'(delay);
    retry_armed = 1'b1;
    sup_phase = (sup_streak >= 16'(block_at)) ? PH_BLOCKED : PH_DEGRADED;
  endtask

  task automatic launch_worker(logic [31:0] now, logic ok);
    cmd_acc = cmd_acc | CMD_START;
    n_attempts++;
    retry_armed = 1'b0;
    attempt_at = now;
    sup_phase = PH_STARTING;
    if (!ok) log_failure(FK_START, now);
  endtask

  task automatic supervise(sup_event_t ev, output result_t r);
    logic          active;
    logic [32:0]   wait_span;
    active = sup_phase != PH_STOPPED;
    cmd_acc = CMD_NONE;
    case (ev.act)
      ACT_START: if (!active) begin
        cmd_acc = cmd_acc | CMD_FLUSH;
        launch_worker(ev.now, ev.ok);
      end
      ACT_STOP: if (active) begin
        cmd_acc = cmd_acc | CMD_STOP;
        retry_armed = 1'b0;
        sup_phase = PH_STOPPED;
      end
      ACT_POLL: if (active) begin
        if (sup_phase == PH_DEGRADED || sup_phase == PH_BLOCKED) begin
          if ({1'b0, ev.now} >= retry_due) launch_worker(ev.now, ev.ok);
        end else if (sup_phase == PH_STARTING) begin
          if (!ev.run) log_failure(FK_EXIT, ev.now);
          else if (fresh_period(ev.now, ev.last)) begin
            ready_at = ev.now;
            sup_phase = PH_READY;
          end else if (has_elapsed(ev.now, attempt_at, to_startup)) begin
            log_failure(FK_STALL, ev.now);
          end
        end else if (sup_phase == PH_READY) begin
          if (!ev.run) log_failure(FK_EXIT, ev.now);
          else if (!fresh_period(ev.now, ev.last)) log_failure(FK_STALL, ev.now);
          else if (sup_streak != 0 && has_elapsed(ev.now, ready_at, to_stable)) begin
            sup_streak = '0;
            sup_kind = FK_NONE;
          end
        end
      end
      default: if (active) begin
        // planned restart
        cmd_acc = cmd_acc | CMD_STOP | CMD_FLUSH;
        n_boundaries++;
        n_planned++;
        sup_kind = FK_NONE;
        sup_streak = '0;
        launch_worker(ev.now, ev.ok);
      end
    endcase

    wait_span = '0;
    if (retry_armed && retry_due > {1'b0, ev.now}) begin
      wait_span = retry_due - {1'b0, ev.now};
      if (wait_span > 33'h0_FFFF_FFFF) wait_span = 33'h0_FFFF_FFFF;
    end

    r.phase          = sup_phase;
    r.failure_kind   = sup_kind;
    r.failure_run    = sup_streak;
    r.attempt_count  = n_attempts;
    r.boundary_count = n_boundaries;
    r.exit_count     = n_exits;
    r.stall_count    = n_stalls;
    r.planned_count  = n_planned;
    r.retry_pending  = retry_armed;
    r.retry_wait_ms  = wait_span[31:0];
    r.commands       = cmd_acc;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns  %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatch_n++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result check, register mirror and prediction, all sampled at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      to_startup   = RST_START_LIMIT;
      to_stall     = RST_STALL_LIMIT;
      to_stable    = RST_STABLE_RESET;
      bo_init      = RST_BO_FIRST;
      bo_max       = RST_BO_CAP;
      block_at     = RST_BLOCK_THRESHOLD;
      sup_phase    = PH_STOPPED;
      sup_kind     = FK_NONE;
      sup_streak   = '0;
      n_attempts   = '0;
      n_boundaries = '0;
      n_exits      = '0;
      n_stalls     = '0;
      n_planned    = '0;
      retry_armed  = 1'b0;
      retry_due    = '0;
      attempt_at   = '0;
      ready_at     = '0;
      status_q.delete();
      outstanding <= 0;
      accepted_n  <= 0;
      steer_phase <= PH_STOPPED;
    end else begin
      if (res.valid && res.ready) begin
        if (status_q.size() == 0) begin
          $display("%0t ns  unexpected result: expected none, actual phase %0d",
                   $time, res.phase);
          mismatch_n++;
        end else begin
          want_r = status_q.pop_front();
          check_field("phase",          32'(want_r.phase),         32'(res.phase));
          check_field("failure_kind",   32'(want_r.failure_kind),  32'(res.failure_kind));
          check_field("failure_run",    32'(want_r.failure_run),   32'(res.failure_run));
          check_field("attempt_count",  want_r.attempt_count,      res.attempt_count);
          check_field("boundary_count", want_r.boundary_count,     res.boundary_count);
          check_field("exit_count",     want_r.exit_count,         res.exit_count);
          check_field("stall_count",    want_r.stall_count,        res.stall_count);
          check_field("planned_count",  want_r.planned_count,      res.planned_count);
          check_field("retry_pending",  32'(want_r.retry_pending), 32'(res.retry_pending));
          check_field("retry_wait_ms",  want_r.retry_wait_ms,      res.retry_wait_ms);
          check_field("commands",       32'(want_r.commands),      32'(res.commands));
        end
      end

      if (cfg.valid && cfg.ready) begin
        case (cfg.idx)
          REG_START_LIMIT:     to_startup = cfg.data;
          REG_STALL_LIMIT:     to_stall   = cfg.data;
          REG_STABLE_RESET:    to_stable  = cfg.data;
          REG_BO_FIRST:        bo_init    = cfg.data;
          REG_BO_CAP:          bo_max     = cfg.data;
          REG_BLOCK_THRESHOLD: block_at   = cfg.data[THR_W-1:0];
          default: ;
        endcase
      end

      if (evt.valid && evt.ready) begin
        seen_ev.act  = evt.action;
        seen_ev.now  = evt.now_ms;
        seen_ev.ok   = evt.start_ok;
        seen_ev.run  = evt.worker_running;
        seen_ev.last = evt.last_period_ms;
        seen_ev.hand = 1'b0;
        seen_ev.ph   = PH_STOPPED;
        seen_ev.fk   = FK_NONE;
        seen_ev.cmd  = CMD_NONE;
        supervise(seen_ev, pred_r);
        if (hand_chk) begin
          pred_r.phase        = hand_ph;
          pred_r.failure_kind = hand_fk;
          pred_r.commands     = hand_cmd;
        end
        status_q.push_back(pred_r);
        accepted_n <= accepted_n + 1;
      end

      outstanding <= status_q.size();
      steer_phase <= sup_phase;
    end
  end

  task automatic offer(sup_event_t ev);
    int unsigned gap;
    evt.valid          <= 1'b1;
    evt.action         <= ev.act;
    evt.now_ms         <= ev.now;
    evt.start_ok       <= ev.ok;
    evt.worker_running <= ev.run;
    evt.last_period_ms <= ev.last;
    hand_chk           <= ev.hand;
    hand_ph            <= ev.ph;
    hand_fk            <= ev.fk;
    hand_cmd           <= ev.cmd;
    @(posedge clk);
    while (!evt.ready) @(posedge clk);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 24);
      gap = $urandom_range(0, 9);
      if (gap != 0) begin
        evt.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    evt.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] data);
    cfg.valid <= 1'b1;
    cfg.idx   <= idx;
    cfg.data  <= data;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
  endtask

  // mostly well-formed traffic: timesteps scaled to the live timeouts, fresh periods,
  // successful starts, with stale or future periods, exits and clock jumps mixed in
  function automatic sup_event_t random_event(reg_set_t s);
    sup_event_t  ev;
    logic [31:0] span;
    logic [31:0] lag;
    int unsigned pick;
    case ($urandom_range(0, 5))
      0: span = 32'(s.stall);
      1: span = 32'(s.startup);
      2: span = 32'(s.max_bo);
      3: span = 32'(s.init_bo) * 4 + 1;
      4: span = 32'(s.stable);
      default: span = 32'd16;
    endcase
    if ($urandom_range(0, 39) == 0) time_cursor = $urandom;
    else time_cursor = time_cursor + $urandom_range(0, span + span / 2);
    ev.now = time_cursor;

    pick = $urandom_range(0, 99);
    if (steer_phase == PH_STOPPED && pick < 85) ev.act = ACT_START;
    else if (pick < 6) ev.act = ACT_START;
    else if (pick < 10) ev.act = ACT_STOP;
    else if (pick < 14) ev.act = ACT_RESTART;
    else ev.act = ACT_POLL;

    ev.ok  = $urandom_range(0, 99) < 85;
    ev.run = $urandom_range(0, 99) < 90;
    lag = 32'(s.stall);
    case ($urandom_range(0, 19))
      0: ev.last = 32'd0;
      1: ev.last = $urandom;
      2: ev.last = ev.now + $urandom_range(1, 10);
      default: ev.last = ev.now - $urandom_range(0, lag + lag / 4 + 1);
    endcase
    ev.hand = 1'b0;
    ev.ph   = PH_STOPPED;
    ev.fk   = FK_NONE;
    ev.cmd  = CMD_NONE;
    return ev;
  endfunction

  // result side: stall pattern of its own, plus one long hold-off to back the block up
  initial begin
    int unsigned mode;
    int unsigned left;
    bit          held;
    res.ready <= 1'b0;
    mode = 0;
    left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && accepted_n >= 700) begin
        held = 1'b1;
        res.ready <= 1'b0;
        repeat (300) @(posedge clk);
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 80);
      end
      left--;
      case (mode)
        0: res.ready <= 1'b1;
        1: res.ready <= 1'($urandom_range(0, 1));
        2: res.ready <= ($urandom_range(0, 3) == 0);
        default: res.ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  initial begin
    reg_set_t    cur;
    int unsigned p;
    int unsigned k;
    rst                <= 1'b1;
    evt.valid          <= 1'b0;
    evt.action         <= ACT_POLL;
    evt.now_ms         <= '0;
    evt.start_ok       <= 1'b0;
    evt.worker_running <= 1'b0;
    evt.last_period_ms <= '0;
    cfg.valid          <= 1'b0;
    cfg.idx            <= REG_START_LIMIT;
    cfg.data           <= '0;
    hand_chk           <= 1'b0;
    hand_ph            <= PH_STOPPED;
    hand_fk            <= FK_NONE;
    hand_cmd           <= CMD_NONE;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (bringup[i]) offer(bringup[i]);

    for (p = 0; p < 7; p++) begin
      if (p < 6) begin
        cur = reg_sets[p];
      end else begin
        cur.startup = 24'($urandom_range(1, 3000));
        cur.stall   = 24'($urandom_range(1, 1500));
        cur.stable  = 24'($urandom_range(1, 20000));
        cur.init_bo = 24'($urandom_range(0, 800));
        cur.max_bo  = 24'($urandom_range(0, 20000));
        cur.thr     = 8'($urandom_range(0, 12));
      end
      drain();
      write_reg(REG_START_LIMIT,     cur.startup);
      write_reg(REG_STALL_LIMIT,     cur.stall);
      write_reg(REG_STABLE_RESET,    cur.stable);
      write_reg(REG_BO_FIRST,        cur.init_bo);
      write_reg(REG_BO_CAP,          cur.max_bo);
      write_reg(REG_BLOCK_THRESHOLD, {{(CFG_W-THR_W){1'b0}}, cur.thr});
      cfg.valid <= 1'b0;
      for (k = 0; k < 230; k++) offer(random_event(cur));
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatch_n == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
